// ===== hw/rtl/rhb_pkg.sv =====
// Shared types and constants for the range histogram binner.
// No dependencies; used by every RTL file of the block except rhb_checker.
package rhb_pkg;

    localparam int NUM_BINS_DEF    = 1024;
    localparam int COUNT_WIDTH_DEF = 32;
    // scaled numerator (v - lo) * w stays below 2^27 for w <= 2047
    localparam int NUM_W           = 28;
    localparam int DEN_W           = 16;
    localparam int PROD_W          = 30;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_EIGHT_BIT  = 3'd0,
        REG_LOW_FIRST  = 3'd1,
        REG_LOWEST     = 3'd2,
        REG_GREATEST   = 3'd3,
        REG_BINS       = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV1S,
        ST_DIV1W,
        ST_DIV2S,
        ST_DIV2W,
        ST_SPAN,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_start;
        logic div_sel;
        logic cap_q1;
        logic span;
        logic bin_rd;
        logic bin_wr;
        logic step;
        logic rd_bin;
        logic clr_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    bin_go;
        logic    div_busy;
        logic    bin_last;
        logic    clr_last;
        logic    out_free;
    } status_t;

endpackage

// ===== hw/rtl/rhb_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on rhb_pkg.
module rhb_div
    import rhb_pkg::*;
#(
    parameter int NW = NUM_W,
    parameter int DW = DEN_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [DW:0]      rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DW:0]      shifted;
    logic [DW+1:0]    trial;

    assign shifted = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            if (!trial[DW+1])
            begin
                rem_reg <= trial[DW:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/rhb_ctrl.sv =====
// Sequencer for the range histogram binner.
// Depends on rhb_pkg; drives rhb_dp through cmd_t and reads status_t.
module rhb_ctrl
    import rhb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.op)
                    OP_CLEAR: state_next = ST_CLEAR;
                    OP_READ:  state_next = ST_READ;
                    OP_PUSH:  state_next = status.bin_go ? ST_MUL : ST_DONE;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_MUL:   state_next = ST_DIV1S;
            ST_DIV1S: state_next = ST_DIV1W;
            ST_DIV1W:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_DIV2S;
                end
            end
            ST_DIV2S: state_next = ST_DIV2W;
            ST_DIV2W:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:   state_next = ST_BIN_RD;
            ST_BIN_RD: state_next = ST_BIN_WR;
            ST_BIN_WR: state_next = status.bin_last ? ST_DONE : ST_BIN_RD;
            ST_READ:   state_next = ST_DONE;
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:   cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_MUL:    cmd.mul = 1'b1;
            ST_DIV1S:  cmd.div_start = 1'b1;
            ST_DIV2S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                cmd.cap_q1    = 1'b1;
            end
            ST_SPAN:   cmd.span = 1'b1;
            ST_BIN_RD: cmd.bin_rd = 1'b1;
            ST_BIN_WR:
            begin
                cmd.bin_wr = 1'b1;
                cmd.step   = !status.bin_last;
            end
            ST_READ:   cmd.rd_bin = 1'b1;
            ST_CLEAR:  cmd.clr_wr = 1'b1;
            ST_DONE:   cmd.load_out = status.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/rhb_dp.sv =====
// Datapath: config registers, sample assembly, scaling, bin store and output register.
// Depends on rhb_pkg and rhb_div.
module rhb_dp
    import rhb_pkg::*;
#(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  in_opcode,
    input  logic [7:0]  in_byte,
    input  logic [9:0]  in_index,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [31:0] bin_count,
    output logic [31:0] max_count,
    output logic        sample_taken
);

    localparam int BIN_W = $clog2(NUM_BINS);

    // configuration
    logic               eight_reg;
    logic               lbf_reg;
    logic signed [15:0] lo_reg;
    logic signed [15:0] hi_reg;
    logic [10:0]        bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eight_reg <= 1'b1;
            lbf_reg   <= 1'b0;
            lo_reg    <= 16'sd0;
            hi_reg    <= 16'sd256;
            bins_reg  <= 11'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EIGHT_BIT: eight_reg <= cfg_data[0];
                REG_LOW_FIRST: lbf_reg   <= cfg_data[0];
                REG_LOWEST:    lo_reg    <= cfg_data;
                REG_GREATEST:  hi_reg    <= cfg_data;
                REG_BINS:      bins_reg  <= cfg_data[10:0];
                default:       ;
            endcase
        end
    end

    logic signed [16:0] range_w;
    logic               range_pos;
    logic [10:0]        eff_w;

    assign range_w   = $signed({hi_reg[15], hi_reg}) - $signed({lo_reg[15], lo_reg});
    assign range_pos = !range_w[16] && (range_w != 17'sd0);
    assign eff_w     = (bins_reg == 11'd0) ? 11'd1 :
                       ((32'(bins_reg) > NUM_BINS) ? 11'(NUM_BINS) : bins_reg);

    // item capture and sample assembly
    opcode_t            op_reg;
    logic [9:0]         idx_reg;
    logic [7:0]         held_reg;
    logic               pending_reg;
    logic signed [16:0] v_reg;
    logic               go_reg;
    logic [15:0]        raw16;
    logic               complete;
    opcode_t            in_op;

    assign in_op    = opcode_t'(in_opcode);
    assign raw16    = lbf_reg ? {in_byte, held_reg} : {held_reg, in_byte};
    assign complete = (in_op == OP_PUSH) && (eight_reg || pending_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            held_reg    <= 8'd0;
            go_reg      <= 1'b0;
            op_reg      <= OP_NONE;
        end
        else if (cmd.load_in)
        begin
            op_reg <= in_op;
            go_reg <= complete && range_pos;
            if (in_op == OP_PUSH)
            begin
                if (eight_reg)
                begin
                    pending_reg <= 1'b0;
                end
                else if (!pending_reg)
                begin
                    held_reg    <= in_byte;
                    pending_reg <= 1'b1;
                end
                else
                begin
                    pending_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            idx_reg <= in_index;
            v_reg   <= eight_reg ? $signed({9'd0, in_byte}) : $signed({raw16[15], raw16});
        end
    end

    // scaling: n1 = (v - lo) * w, n2 = n1 + w
    logic signed [17:0]       diff;
    logic signed [PROD_W-1:0] n1_reg;
    logic signed [PROD_W-1:0] n2;
    logic signed [PROD_W-1:0] n_sel;
    logic [NUM_W-1:0]         div_num;
    logic [NUM_W-1:0]         div_quo;
    logic                     div_busy;
    logic [NUM_W-1:0]         q1_reg;

    assign diff    = $signed({v_reg[16], v_reg}) - $signed({{2{lo_reg[15]}}, lo_reg});
    assign n2      = n1_reg + $signed(PROD_W'(eff_w));
    assign n_sel   = cmd.div_sel ? n2 : n1_reg;
    // negative numerators land on bin 0 after clamping
    assign div_num = (n_sel[PROD_W-1] || n_sel == '0) ? '0 : n_sel[NUM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            n1_reg <= PROD_W'(diff * $signed({1'b0, eff_w}));
        end
        if (cmd.cap_q1)
        begin
            q1_reg <= div_quo;
        end
    end

    rhb_div #(
        .NW (NUM_W),
        .DW (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (range_w[15:0]),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // bin span
    logic [NUM_W-1:0] wm1;
    logic [NUM_W-1:0] first_c;
    logic [NUM_W-1:0] l0;
    logic [NUM_W-1:0] last_c;
    logic [BIN_W-1:0] cur_reg;
    logic [BIN_W-1:0] last_reg;

    always_comb
    begin
        wm1     = NUM_W'(eff_w) - 1'b1;
        first_c = (q1_reg > wm1) ? wm1 : q1_reg;
        l0      = (div_quo == '0) ? '0 : div_quo - 1'b1;
        last_c  = (l0 > wm1) ? wm1 : l0;
        if (last_c < first_c)
        begin
            last_c = first_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.span)
        begin
            cur_reg  <= first_c[BIN_W-1:0];
            last_reg <= last_c[BIN_W-1:0];
        end
        else if (cmd.step)
        begin
            cur_reg <= cur_reg + 1'b1;
        end
    end

    // bin store
    logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [COUNT_WIDTH-1:0] inc;
    logic [COUNT_WIDTH-1:0] max_reg;
    logic [BIN_W-1:0]       clr_reg;
    logic                   clr_last;
    logic [15:0]            idx_ext;
    logic [BIN_W-1:0]       idx_addr;
    logic                   idx_ok;
    logic [BIN_W-1:0]       waddr;
    logic [BIN_W-1:0]       raddr;

    assign inc      = (&rd_data_reg) ? rd_data_reg : rd_data_reg + 1'b1;
    assign clr_last = (clr_reg == BIN_W'(NUM_BINS - 1));
    assign idx_ext  = {6'd0, idx_reg};
    assign idx_addr = idx_ext[BIN_W-1:0];
    assign idx_ok   = (32'(idx_reg) < NUM_BINS);
    assign waddr    = cmd.clr_wr ? clr_reg : cur_reg;
    assign raddr    = cmd.rd_bin ? idx_addr : cur_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr || cmd.bin_wr)
        begin
            mem[waddr] <= cmd.clr_wr ? '0 : inc;
        end
        if (cmd.bin_rd || cmd.rd_bin)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            max_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_reg <= clr_last ? '0 : clr_reg + 1'b1;
            max_reg <= '0;
        end
        else if (cmd.bin_wr && (inc > max_reg))
        begin
            max_reg <= inc;
        end
    end

    // output register
    logic        out_valid_reg;
    logic [31:0] bin_count_reg;
    logic [31:0] max_count_reg;
    logic        taken_reg;
    logic [63:0] rd_ext;
    logic [63:0] max_ext;

    assign rd_ext  = 64'(rd_data_reg);
    assign max_ext = 64'(max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            bin_count_reg <= (op_reg == OP_READ && idx_ok) ? rd_ext[31:0] : 32'd0;
            max_count_reg <= max_ext[31:0];
            taken_reg     <= go_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bin_count    = bin_count_reg;
    assign max_count    = max_count_reg;
    assign sample_taken = taken_reg;

    assign status.op       = op_reg;
    assign status.bin_go   = go_reg;
    assign status.div_busy = div_busy;
    assign status.bin_last = (cur_reg == last_reg);
    assign status.clr_last = clr_last;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// ===== hw/rtl/range_histogram_binner_unit.sv =====
// Top level of the range histogram binner.
// Depends on rhb_pkg, rhb_ctrl, rhb_dp (and rhb_div below it).
//
//  channel | direction | handshake        | payload
//  s_*     | in        | tvalid/tready    | tdata: opcode, data_byte, bin_index
//  m_*     | out       | tvalid/tready    | tdata: bin_count, max_count; tuser: sample_taken
//  cfg_*   | in        | cfg_we only      | cfg_index, cfg_data
//
// One item at a time. A binned sample is scaled, then takes two 28-step divisions on the
// shared divider, then each bin in its span is read and written back in turn. A clear
// walks the store. After reset the store is swept before s_tready rises. A result not
// yet taken from the output register holds the next item in its final state, which
// blocks the next transfer.
module range_histogram_binner_unit
    import rhb_pkg::*;
#(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] opcode, [9:2] data_byte, [19:10] bin_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] bin_count, [63:32] max_count
    output logic        m_tuser    // [0] sample_taken
);

    cmd_t        cmd;
    status_t     status;
    logic [31:0] bin_count;
    logic [31:0] max_count;

    rhb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rhb_dp #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_opcode    (s_tdata[1:0]),
        .in_byte      (s_tdata[9:2]),
        .in_index     (s_tdata[19:10]),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .bin_count    (bin_count),
        .max_count    (max_count),
        .sample_taken (m_tuser)
    );

    assign m_tdata = {max_count, bin_count};

endmodule

// ===== hw/rtl/rhb_checker.sv =====
// Port-level checks for range_histogram_binner_unit, attached by bind.
// No package dependency.
module rhb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer accepted while busy");

    a_push_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("binned sample carries a bin count");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared in the cycle after transfer");

endmodule

bind range_histogram_binner_unit rhb_checker u_rhb_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for range_histogram_binner_unit: streams bytes, reads and clears,
// predicts every result in place and compares it field by field. Depends on rhb_pkg.
module tb_top;
    import rhb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] bin_count;
        logic [31:0] max_count;
        logic        sample_taken;
    } hist_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    range_histogram_binner_unit dut (.*);

    always #10 clk = ~clk;

    // predictor state
    logic [31:0]        hist_bins [1024];
    logic [31:0]        peak_count;
    logic [7:0]         held_byte;
    logic               byte_held;
    logic               mode_8bit;
    logic               low_first;
    logic signed [15:0] edge_lo;
    logic signed [15:0] edge_hi;
    logic [10:0]        bins_used;

    logic [23:0]  item_queue [$];
    hist_result_t result_queue [$];
    int           n_queued = 0;
    int           n_accepted = 0;
    int           n_checked = 0;
    int           n_taken = 0;
    int           errors = 0;
    int           gap_left = 0;
    bit           calm = 1'b0;
    bit           in_done = 1'b0;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic bit bin_sample(longint v);
        longint lo, rg, w, first, last;
        lo = edge_lo;
        rg = longint'(edge_hi) - lo;
        w = bins_used;
        if (rg <= 0)
            return 1'b0;
        if (w < 1)
            w = 1;
        if (w > 1024)
            w = 1024;
        first = floor_div((v - lo) * w, rg);
        last = floor_div((v + 1 - lo) * w, rg);
        if (last > 0)
            last--;
        if (first < 0)
            first = 0;
        if (last < 0)
            last = 0;
        if (first > w - 1)
            first = w - 1;
        if (last > w - 1)
            last = w - 1;
        if (last < first)
            last = first;
        for (longint j = first; j <= last; j++)
        begin
            if (hist_bins[j] != 32'hFFFF_FFFF)
                hist_bins[j]++;
            if (hist_bins[j] > peak_count)
                peak_count = hist_bins[j];
        end
        return 1'b1;
    endfunction

    function automatic hist_result_t predict_item(logic [23:0] d);
        hist_result_t r;
        opcode_t op;
        logic [7:0] b;
        logic [9:0] idx;
        longint raw;
        op = opcode_t'(d[1:0]);
        b = d[9:2];
        idx = d[19:10];
        r.bin_count = '0;
        r.sample_taken = 1'b0;
        case (op)
            OP_PUSH:
            begin
                if (mode_8bit)
                begin
                    byte_held = 1'b0;
                    r.sample_taken = bin_sample(longint'(b));
                end
                else if (!byte_held)
                begin
                    held_byte = b;
                    byte_held = 1'b1;
                end
                else
                begin
                    raw = low_first ? held_byte + 256 * b : held_byte * 256 + b;
                    if (raw >= 32768)
                        raw -= 65536;
                    byte_held = 1'b0;
                    r.sample_taken = bin_sample(raw);
                end
            end
            OP_READ:  r.bin_count = hist_bins[idx];
            OP_CLEAR:
            begin
                foreach (hist_bins[i])
                    hist_bins[i] = '0;
                peak_count = '0;
            end
            default: ;
        endcase
        r.max_count = peak_count;
        return r;
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_done)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (item_queue.size() > 0)
                begin
                    s_tdata <= item_queue.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left <= pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= (pick_gap() == 0);
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        hist_result_t exp_r;
        in_done <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            result_queue.push_back(predict_item(s_tdata));
            n_accepted++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (result_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h/%b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                exp_r = result_queue.pop_front();
                n_checked++;
                if (m_tuser)
                    n_taken++;
                if (m_tdata[31:0] !== exp_r.bin_count)
                begin
                    errors++;
                    $display("%0t: bin_count expected %0d actual %0d",
                             $time, exp_r.bin_count, m_tdata[31:0]);
                end
                if (m_tdata[63:32] !== exp_r.max_count)
                begin
                    errors++;
                    $display("%0t: max_count expected %0d actual %0d",
                             $time, exp_r.max_count, m_tdata[63:32]);
                end
                if (m_tuser !== exp_r.sample_taken)
                begin
                    errors++;
                    $display("%0t: sample_taken expected %b actual %b",
                             $time, exp_r.sample_taken, m_tuser);
                end
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_EIGHT_BIT: mode_8bit = val[0];
            REG_LOW_FIRST: low_first = val[0];
            REG_LOWEST:    edge_lo = val;
            REG_GREATEST:  edge_hi = val;
            REG_BINS:      bins_used = val[10:0];
            default: ;
        endcase
    endtask

    task automatic set_all(bit m8, bit lf, logic [15:0] lo, logic [15:0] hi,
                           logic [10:0] w);
        write_reg(REG_EIGHT_BIT, 16'(m8));
        write_reg(REG_LOW_FIRST, 16'(lf));
        write_reg(REG_LOWEST, lo);
        write_reg(REG_GREATEST, hi);
        write_reg(REG_BINS, 16'(w));
    endtask

    task automatic queue_item(opcode_t op, logic [7:0] b, logic [9:0] idx);
        item_queue.push_back({4'b0, idx, b, op});
        n_queued++;
    endtask

    // push a 16-bit sample as two bytes in the configured order
    task automatic queue_pair(logic [15:0] v);
        queue_item(OP_PUSH, low_first ? v[7:0] : v[15:8], '0);
        queue_item(OP_PUSH, low_first ? v[15:8] : v[7:0], '0);
    endtask

    task automatic drain();
        wait (n_accepted == n_queued && result_queue.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic random_phase(int n_items);
        int r, span;
        longint v, lo, hi;
        lo = edge_lo;
        hi = edge_hi;
        span = (hi > lo) ? int'(hi - lo) : 256;
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    v = lo - span / 8 + $urandom_range(0, span + span / 4);
                    if (mode_8bit)
                        queue_item(OP_PUSH, v[7:0], '0);
                    else
                        queue_pair(v[15:0]);
                end
                else
                    queue_item(OP_PUSH, 8'($urandom_range(0, 255)), '0);
            end
            else if (r < 90)
                queue_item(OP_READ, 8'($urandom_range(0, 255)),
                           10'($urandom_range(0, 9) < 6 ?
                               $urandom_range(0, bins_used > 1 ? bins_used - 1 : 0) :
                               $urandom_range(0, 1023)));
            else if (r < 93)
                queue_item(OP_CLEAR, 8'($urandom_range(0, 255)),
                           10'($urandom_range(0, 1023)));
            else
                queue_item(OP_NONE, 8'($urandom_range(0, 255)),
                           10'($urandom_range(0, 1023)));
        end
    endtask

    initial
    begin
        int lo_v, hi_v, w_v, n;
        foreach (hist_bins[i])
            hist_bins[i] = '0;
        peak_count = '0;
        held_byte = '0;
        byte_held = 1'b0;
        mode_8bit = 1'b1;
        low_first = 1'b0;
        edge_lo = 16'sd0;
        edge_hi = 16'sd256;
        bins_used = 11'd256;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: byte extremes, reads inside, past W and out of use, no-op, clear
        queue_item(OP_PUSH, 8'h00, '0);
        queue_item(OP_PUSH, 8'hFF, '0);
        queue_item(OP_PUSH, 8'h80, '0);
        queue_item(OP_READ, '0, 10'd0);
        queue_item(OP_READ, '0, 10'd255);
        queue_item(OP_READ, '0, 10'd1023);
        queue_item(OP_NONE, 8'hFF, 10'h3FF);
        queue_item(OP_CLEAR, '0, '0);
        queue_item(OP_READ, '0, 10'd0);
        drain();

        // full signed range, below and above clamp, pair held across a clear
        set_all(1'b0, 1'b0, 16'h8000, 16'h7FFF, 11'd1024);
        queue_pair(16'h8000);
        queue_pair(16'h7FFF);
        queue_item(OP_PUSH, 8'h12, '0);
        queue_item(OP_CLEAR, '0, '0);
        queue_item(OP_PUSH, 8'h34, '0);
        queue_item(OP_READ, '0, 10'd1023);
        drain();

        // an empty range drops samples; a byte held then dropped by 8-bit mode
        set_all(1'b0, 1'b1, 16'd100, 16'd100, 11'd0);
        queue_pair(16'd100);
        queue_item(OP_PUSH, 8'h55, '0);
        drain();
        set_all(1'b1, 1'b1, 16'hFFF0, 16'h0010, 11'd2047);
        queue_item(OP_PUSH, 8'h05, '0);
        queue_item(OP_PUSH, 8'hF8, '0);
        queue_item(OP_READ, '0, 10'd1023);
        drain();

        for (int ph = 0; ph < 30; ph++)
        begin
            calm = ($urandom_range(0, 4) == 0);
            lo_v = $urandom_range(0, 3) == 0 ? -32768 : $urandom_range(0, 600) - 300;
            hi_v = lo_v + $urandom_range(1, 400);
            w_v = $urandom_range(1, 64);
            case (ph)
                0: begin lo_v = -32768; hi_v = 32767; w_v = 1024; end
                1: begin lo_v = 32766; hi_v = 32767; w_v = 1; end
                2: begin lo_v = 0; hi_v = 4; w_v = 1024; end
                3: begin lo_v = 0; hi_v = 300; w_v = 0; end
                4: begin lo_v = 50; hi_v = -50; end
                default:
                begin
                    if ($urandom_range(0, 5) == 0)
                        w_v = $urandom_range(0, 2047);
                    if (hi_v > 32767)
                        hi_v = 32767;
                end
            endcase
            set_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    16'(lo_v), 16'(hi_v), 11'(w_v));
            // wide spans are slow: keep those phases short
            n = (w_v > hi_v - lo_v && w_v > 64) ? 8 : 38;
            random_phase(n);
            drain();
        end

        $display("Covered %0d items, %0d results checked, %0d samples binned.",
                 n_queued, n_checked, n_taken);
        $display("Both modes, both byte orders, clamped and inverted ranges, reads and clears.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
